// ===== rtl/core/shrp_pkg.sv =====
// ----------------------------------------------------------------------------
// shrp_pkg
// Shared types and constants for the 3x3 five-point sharpening stream.
// ----------------------------------------------------------------------------
`default_nettype none

package shrp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;

  // Input word kinds carried on tuser
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam int CH_W   = 3;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int CFG_DW = 13;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Operands of one result word, handed from the front to the back
  typedef struct packed {
    logic             zero;
    logic             frame_end;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/shrp_front.sv =====
// ----------------------------------------------------------------------------
// shrp_front
// Frame counters, word classification, line stores and neighbor window.
// Emits the operands of each result word into the operand queue.
// ----------------------------------------------------------------------------
`default_nettype none

module shrp_front import shrp_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [PIX_W-1:0]  in_tdata,
  input  wire logic              in_tuser,
  input  wire logic [QCW-1:0]    q_count,
  output logic                   q_push,
  output op_t                    q_din
);

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int LW  = AW + 1;
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [CH_W-1:0]  ch_r;
  logic [WID_W-1:0] wid_r;
  logic [HGT_W-1:0] hgt_r;

  logic [AW-1:0]    m_r;
  logic [WID_W-1:0] px_r;
  logic [CHW-1:0]   sub_r;
  logic [HGT_W-1:0] row_r;
  logic [LW-1:0]    dc_r;
  logic             bank_r;

  logic [CH_W-1:0]  ch_eff;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [13:0]      len_prod;
  logic [LW-1:0]    row_len;
  logic [AW-1:0]    m_plus;
  logic [LW-1:0]    dc_nxt;

  logic in_acc;
  logic is_pix;
  logic frame_full;
  logic pix_ok;
  logic drain_ok;
  logic emit_pix;
  logic border;
  logic row_end;
  logic last_drain;
  logic sub_wrap;

  logic [PIX_W-1:0] mem0 [LINE_DEPTH];
  logic [PIX_W-1:0] mem1 [LINE_DEPTH];
  logic [PIX_W-1:0] rd0a_r, rd0b_r, rd1a_r, rd1b_r;

  logic             v1_r;
  logic             img1_r;
  logic             emit1_r;
  logic             zero1_r;
  logic             fe1_r;
  logic             bank1_r;
  logic [PIX_W-1:0] pix1_r;

  logic [PIX_W-1:0] dl_r [MAX_CHANNELS];
  logic [PIX_W-1:0] cur;
  logic [PIX_W-1:0] right;
  logic [PIX_W-1:0] up;
  logic [PIX_W-1:0] left;

  // Clamp the raw register bits to their usable ranges
  always_comb begin
    if (ch_r == '0) begin
      ch_eff = CH_W'(1);
    end else if (32'(ch_r) > MAX_CHANNELS) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = ch_r;
    end
    if (wid_r < WID_W'(3)) begin
      w_eff = WID_W'(3);
    end else if (32'(wid_r) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = wid_r;
    end
    if (hgt_r < HGT_W'(3)) begin
      h_eff = HGT_W'(3);
    end else if (32'(hgt_r) > MAX_HEIGHT) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = hgt_r;
    end
  end

  assign len_prod = 14'(w_eff) * 14'(ch_eff);
  assign row_len  = LW'(len_prod);
  assign m_plus   = m_r + AW'(ch_eff);
  assign dc_nxt   = dc_r + LW'(1);

  assign in_tready = ((QCW+1)'(q_count) + (QCW+1)'(v1_r)) < (QCW+1)'(QDEPTH);
  assign in_acc    = in_tvalid && in_tready;

  assign is_pix     = (in_tuser == KIND_PIXEL);
  assign frame_full = (row_r >= h_eff);
  assign pix_ok     = is_pix && !frame_full && (LW'(m_r) < row_len);
  assign drain_ok   = !is_pix && frame_full;
  assign emit_pix   = pix_ok && (row_r != '0);
  assign border     = (row_r < HGT_W'(2)) || (px_r == '0) || (px_r == w_eff - WID_W'(1));
  assign row_end    = (LW'(m_r) + LW'(1)) >= row_len;
  assign last_drain = dc_nxt >= row_len;
  assign sub_wrap   = (CH_W'(sub_r) == ch_eff - CH_W'(1));

  // Configuration registers and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r   <= CH_W'(3);
      wid_r  <= WID_W'(640);
      hgt_r  <= HGT_W'(480);
      m_r    <= '0;
      px_r   <= '0;
      sub_r  <= '0;
      row_r  <= '0;
      dc_r   <= '0;
      bank_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNELS: begin
          ch_r  <= cfg_wdata[CH_W-1:0];
          m_r   <= '0;
          px_r  <= '0;
          sub_r <= '0;
          row_r <= '0;
          dc_r  <= '0;
        end
        CFG_WIDTH: begin
          wid_r <= cfg_wdata[WID_W-1:0];
          m_r   <= '0;
          px_r  <= '0;
          sub_r <= '0;
          row_r <= '0;
          dc_r  <= '0;
        end
        CFG_HEIGHT: begin
          hgt_r <= cfg_wdata[HGT_W-1:0];
          m_r   <= '0;
          px_r  <= '0;
          sub_r <= '0;
          row_r <= '0;
          dc_r  <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (pix_ok) begin
        if (row_end) begin
          // swap line roles and advance to the next row
          m_r    <= '0;
          px_r   <= '0;
          sub_r  <= '0;
          row_r  <= row_r + HGT_W'(1);
          bank_r <= !bank_r;
        end else begin
          m_r <= m_r + AW'(1);
          if (sub_wrap) begin
            sub_r <= '0;
            px_r  <= px_r + WID_W'(1);
          end else begin
            sub_r <= sub_r + CHW'(1);
          end
        end
      end else if (drain_ok) begin
        if (last_drain) begin
          m_r   <= '0;
          px_r  <= '0;
          sub_r <= '0;
          row_r <= '0;
          dc_r  <= '0;
        end else begin
          dc_r <= dc_nxt;
        end
      end
    end
  end

  // Line store 0: upper line when bank_r is low, middle line otherwise
  always_ff @(posedge clk) begin
    if (in_acc && pix_ok && !bank_r) begin
      mem0[m_r] <= in_tdata;
    end
    rd0a_r <= mem0[m_r];
    rd0b_r <= mem0[m_plus];
  end

  // Line store 1: upper line when bank_r is high
  always_ff @(posedge clk) begin
    if (in_acc && pix_ok && bank_r) begin
      mem1[m_r] <= in_tdata;
    end
    rd1a_r <= mem1[m_r];
    rd1b_r <= mem1[m_plus];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_acc && (pix_ok || drain_ok);
    end
  end

  always_ff @(posedge clk) begin
    img1_r  <= pix_ok;
    emit1_r <= emit_pix || drain_ok;
    zero1_r <= drain_ok || border;
    fe1_r   <= drain_ok && last_drain;
    bank1_r <= bank_r;
    pix1_r  <= in_tdata;
  end

  assign cur   = bank1_r ? rd0a_r : rd1a_r;
  assign right = bank1_r ? rd0b_r : rd1b_r;
  assign up    = bank1_r ? rd1a_r : rd0a_r;
  assign left  = dl_r[CHW'(ch_eff - CH_W'(1))];

  // Window of middle-line words, one tap per channel back
  always_ff @(posedge clk) begin
    if (v1_r && img1_r) begin
      dl_r[0] <= cur;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end
  end

  assign q_push          = v1_r && emit1_r;
  assign q_din.zero      = zero1_r;
  assign q_din.frame_end = fe1_r;
  assign q_din.center    = cur;
  assign q_din.left      = left;
  assign q_din.right     = right;
  assign q_din.up        = up;
  assign q_din.down      = pix1_r;

endmodule

`default_nettype wire

// ===== rtl/core/shrp_queue.sv =====
// ----------------------------------------------------------------------------
// shrp_queue
// Short operand queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module shrp_queue import shrp_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire op_t            din,
  input  wire logic           pop,
  output op_t                 dout,
  output logic [QCW-1:0]      count
);

  op_t            slot_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QCW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QAW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QAW'(1);
      end
      count_r <= count_r + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  assign dout  = slot_r[rp_r];
  assign count = count_r;

endmodule

`default_nettype wire

// ===== rtl/core/shrp_back.sv =====
// ----------------------------------------------------------------------------
// shrp_back
// Five-point sum, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module shrp_back import shrp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_avail,
  input  wire op_t              q_dout,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [PIX_W-1:0]      out_tdata,
  output logic                  out_tlast
);

  logic [10:0]      pos;
  logic [9:0]       neg;
  logic [11:0]      diff;
  logic [PIX_W-1:0] sat;

  logic             vld_r;
  logic [PIX_W-1:0] data_r;
  logic             last_r;

  assign pos  = {1'b0, q_dout.center, 2'b00} + 11'(q_dout.center);
  assign neg  = 10'(q_dout.left) + 10'(q_dout.right) + 10'(q_dout.up) + 10'(q_dout.down);
  assign diff = 12'(pos) - 12'(neg);

  always_comb begin
    if (q_dout.zero || diff[11]) begin
      sat = '0;
    end else if (diff[10:8] != 3'b000) begin
      sat = '1;
    end else begin
      sat = diff[7:0];
    end
  end

  // advance when the output register is empty or being drained
  assign q_pop = q_avail && (!vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= sat;
      last_r <= q_dout.frame_end;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// ===== rtl/core/sharpen_3x3_stream.sv =====
// ----------------------------------------------------------------------------
// sharpen_3x3_stream
// Five-point Laplacian sharpening of an interleaved 8-bit raster stream.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle in and out while out_tready stays high.
// Path: a result reaches out_tdata through the line store read stage, then
//   the operand queue and the output register.
// The operand queue is four words deep; in_tready drops while the queued
//   words plus the word in the line store read stage reach four.
// Reset (rst_n low, synchronous) restores registers to 3 channels, 640x480,
//   restarts the frame and empties the pipeline; line stores are not cleared.
`default_nettype none

module sharpen_3x3_stream import shrp_pkg::*; #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [PIX_W-1:0]  in_tdata,   // [7:0] pixel_value
  input  wire logic              in_tuser,   // [0] kind
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [PIX_W-1:0]       out_tdata,  // [7:0] result_value
  output logic                   out_tlast
);

  logic           q_push;
  logic           q_pop;
  op_t            q_din;
  op_t            q_dout;
  logic [QCW-1:0] q_count;
  logic           q_avail;

  assign q_avail = (q_count != '0);

  shrp_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  shrp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .count (q_count)
  );

  shrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_avail    (q_avail),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count < QCW'(QDEPTH)))
    else $error("operand queue overflow");

  a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_count != '0))
    else $error("operand queue underflow");

  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == '0))
    else $error("frame end word is not a border zero");

endmodule

`default_nettype wire

// ===== tb/sharpen_3x3_stream_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sharpen_3x3_stream_tb
// Self-checking bench for the five-point sharpening stream. A small
// scoreboard class keeps its own line stores and frame counters, predicts
// each result word from the accepted input words and checks the output
// stream in order. Stimulus: a directed clamp and noise frame, random small
// frames under changing geometry and back-pressure, then the first rows of
// one widest and one tallest frame.
// ----------------------------------------------------------------------------

module sharpen_3x3_stream_tb;
  import shrp_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_CHANNELS = 4;
  localparam int LINE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;
  localparam int CENTER_GAIN  = 5;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic             frame_end;
    logic [PIX_W-1:0] value;
  } result_t;

  class laplace_sharpener;
    logic [CH_W-1:0]  channels;
    logic [WID_W-1:0] width_px;
    logic [HGT_W-1:0] height_rows;
    logic [PIX_W-1:0] upper_row  [LINE_DEPTH];
    logic [PIX_W-1:0] middle_row [LINE_DEPTH];
    int unsigned      col;
    int unsigned      row;
    int unsigned      drained;
    result_t          pending_pixels[$];
    int               errors;

    function new();
      channels    = 3;
      width_px    = 640;
      height_rows = 480;
      errors      = 0;
      restart();
    endfunction

    function void restart();
      col     = 0;
      row     = 0;
      drained = 0;
    endfunction

    function int unsigned eff_channels();
      if (channels < 1) return 1;
      if (channels > MAX_CHANNELS) return MAX_CHANNELS;
      return channels;
    endfunction

    function int unsigned eff_width();
      if (width_px < 3) return 3;
      if (width_px > MAX_WIDTH) return MAX_WIDTH;
      return width_px;
    endfunction

    function int unsigned eff_height();
      if (height_rows < 3) return 3;
      if (height_rows > MAX_HEIGHT) return MAX_HEIGHT;
      return height_rows;
    endfunction

    function int unsigned row_len();
      return eff_channels() * eff_width();
    endfunction

    // A write to any real register restarts the frame; the lines are kept.
    function void write_reg(logic [1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_CHANNELS: channels = val[CH_W-1:0];
        CFG_WIDTH:    width_px = val[WID_W-1:0];
        CFG_HEIGHT:   height_rows = val[HGT_W-1:0];
        default: return;
      endcase
      restart();
    endfunction

    function void take_word(logic kind, logic [PIX_W-1:0] pix);
      int unsigned      ch;
      int unsigned      w;
      int unsigned      len;
      int unsigned      px;
      int               acc;
      result_t          r;
      logic [PIX_W-1:0] t;
      ch  = eff_channels();
      w   = eff_width();
      len = ch * w;
      r   = '0;
      if (kind == KIND_PIXEL) begin
        // drop components past the end of the frame
        if (row >= eff_height() || col >= len) return;
        if (row >= 1) begin
          px = col / ch;
          if (row >= 2 && px >= 1 && px + 1 < w) begin
            acc = CENTER_GAIN * int'(middle_row[col]) - int'(middle_row[col - ch])
                - int'(middle_row[col + ch]) - int'(upper_row[col]) - int'(pix);
            if (acc < 0) acc = 0;
            else if (acc > 255) acc = 255;
            r.value = acc[PIX_W-1:0];
          end
          pending_pixels.push_back(r);
        end
        upper_row[col] = pix;
        col++;
        if (col >= len) begin
          col = 0;
          for (int i = 0; i < len; i++) begin
            t             = upper_row[i];
            upper_row[i]  = middle_row[i];
            middle_row[i] = t;
          end
          row++;
        end
      end else begin
        // drain ticks count only once the whole frame is in
        if (row < eff_height()) return;
        drained++;
        if (drained >= len) begin
          r.frame_end = 1'b1;
          restart();
        end
        pending_pixels.push_back(r);
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] value, logic last);
      result_t want;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result word: result_value %0d frame_end %0b", value, last);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (value !== want.value) begin
        $error("result_value: expected %0d, actual %0d", want.value, value);
        errors++;
      end
      if (last !== want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata;    // [7:0] pixel_value
  logic              in_tuser;    // [0] kind
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [PIX_W-1:0]  out_tdata;   // [7:0] result_value
  logic              out_tlast;

  laplace_sharpener sharpener = new();
  int send_idle_pct = 28;
  int recv_idle_pct = 56;
  int words_sent    = 0;

  sharpen_3x3_stream i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sharpener.check_result(out_tdata, out_tlast);
    end
  end

  task automatic push_word(input logic kind, input logic [PIX_W-1:0] pix);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = pix;
    do @(posedge clk); while (!in_tready);
    sharpener.take_word(kind, pix);
  endtask

  // Hold the sender until every pending word is out and the pipe is empty.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sharpener.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    sharpener.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] pixel_sample();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame plus its drain ticks, with ignored words mixed in; a broken
  // frame stops at a random point.
  task automatic run_frame(input bit broken);
    int frame_words;
    int cut;
    frame_words = sharpener.row_len() * sharpener.eff_height();
    cut = frame_words + sharpener.row_len();
    if (broken) cut = $urandom_range(1, cut - 1);
    for (int n = 0; n < cut; n++) begin
      if ($urandom_range(0, 99) < 4) begin
        push_word(n < frame_words ? KIND_DRAIN : KIND_PIXEL, pixel_sample());
      end
      if ($urandom_range(0, 99) < 2) settle();
      push_word(n < frame_words ? KIND_PIXEL : KIND_DRAIN, pixel_sample());
      words_sent++;
    end
  endtask

  // Leading part of a frame only: image words, no drain.
  task automatic run_partial(input int count);
    for (int n = 0; n < count; n++) begin
      push_word(KIND_PIXEL, pixel_sample());
      words_sent++;
    end
  endtask

  task automatic run_random(input int count);
    int  target;
    bit  broken;
    bit  fresh_needed;
    target       = words_sent + count;
    fresh_needed = 1'b1;
    while (words_sent < target) begin
      if (fresh_needed || $urandom_range(0, 1) == 0) begin
        settle();
        write_reg(CFG_CHANNELS, CFG_DW'($urandom_range(0, 7)));
        write_reg(CFG_WIDTH, CFG_DW'($urandom_range(0, 5)));
        write_reg(CFG_HEIGHT, CFG_DW'($urandom_range(0, 4)));
      end
      broken = ($urandom_range(0, 9) == 0);
      run_frame(broken);
      fresh_needed = broken;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_CHANNELS;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser  = KIND_PIXEL;
    in_tdata  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: a few row-0 words and an early drain tick, no results
    push_word(KIND_PIXEL, 8'h5a);
    push_word(KIND_DRAIN, 8'h00);
    push_word(KIND_PIXEL, 8'hff);
    push_word(KIND_PIXEL, 8'h00);
    settle();

    // 2 channels, width and height below range: channel 0 clamps high,
    // channel 1 clamps low
    write_reg(CFG_CHANNELS, 2);
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 1);
    for (int r = 0; r < 3; r++) begin
      for (int px = 0; px < 3; px++) begin
        for (int c = 0; c < 2; c++) begin
          push_word(KIND_PIXEL, ((r == 1 && px == 1) == (c == 0)) ? 8'hff : 8'h00);
        end
      end
      if (r == 0) begin
        // unused index must not restart the frame
        settle();
        write_reg(CFG_UNUSED, '1);
      end
      if (r == 1) push_word(KIND_DRAIN, 8'h00);
    end
    push_word(KIND_PIXEL, 8'h77);
    repeat (6) push_word(KIND_DRAIN, 8'h00);

    run_random(120);
    settle();
    send_idle_pct = 56;
    recv_idle_pct = 28;
    run_random(120);
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(120);

    // widest rows, channels above range: row 0 only, no results
    settle();
    write_reg(CFG_CHANNELS, 7);
    write_reg(CFG_WIDTH, 2047);
    write_reg(CFG_HEIGHT, 0);
    run_partial(20);

    // tallest frame, zero channels and width: first rows only
    settle();
    write_reg(CFG_CHANNELS, 0);
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 8191);
    run_partial(30);

    settle();
    if (sharpener.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/shrp_pkg.sv
rtl/core/shrp_front.sv
rtl/core/shrp_queue.sv
rtl/core/shrp_back.sv
rtl/core/sharpen_3x3_stream.sv
tb/sharpen_3x3_stream_tb.sv
